### src/fvn_pkg.sv
// Shared types and constants of the fractal value noise block.
package fvn_pkg;

  // Hash constants
  localparam logic [31:0] MIX_C1   = 32'h7feb352d;
  localparam logic [31:0] MIX_C2   = 32'h846ca68b;
  localparam logic [31:0] AXIS_KX  = 32'h9e3779b9;
  localparam logic [31:0] AXIS_KY  = 32'h85ebca6b;
  localparam logic [31:0] AXIS_KZ  = 32'hc2b2ae35;
  localparam logic [31:0] VAL_MASK = 32'h00ffffff;

  // Seed advance per octave
  localparam logic [31:0] SEED_STEP_2D = 32'd911;
  localparam logic [31:0] SEED_STEP_3D = 32'd577;

  // Quotient bits of the final normalization
  localparam int unsigned DIV_STEPS = 17;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_SEED   = 2'd0;
  localparam logic [1:0] REG_OCTAVE = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [3:0] OCTAVE_RESET = 4'd4;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EASE,
    OP_AXIS,
    OP_CORNER,
    OP_BLEND,
    OP_ACCUM,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [2:0] idx;
    logic [1:0] sub;
    logic [1:0] lvl;
  } cmd_t;

endpackage

### src/fvn_datapath.sv
// Datapath: coordinates, hash unit, ease/blend multiplier, accumulator, divider.
module fvn_datapath #(
  parameter int MAX_OCTAVES   = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  fvn_pkg::cmd_t      cmd_i,
  input  logic        [31:0] noise_seed_i,
  input  logic               three_dim_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic signed [31:0] z_coord_i,
  output logic signed [15:0] noise_value_o
);

  localparam int AW = MAX_OCTAVES + 26;

  function automatic logic [31:0] xs16(input logic [31:0] v);
    return v ^ (v >> 16);
  endfunction

  function automatic logic [31:0] xs15(input logic [31:0] v);
    return v ^ (v >> 15);
  endfunction

  logic [31:0]             coord_q [3];
  logic                    d3_q;
  logic [31:0]             seed_q;
  logic signed [AW-1:0]    acc_q;
  logic [MAX_OCTAVES-1:0]  den_q;
  logic [31:0]             hp_q;
  logic [31:0]             hax_q [3][2];
  logic signed [44:0]      prod_q;
  logic [16:0]             ease_q [3];
  logic [23:0]             pl_q [4];
  logic [23:0]             ph_q [4];
  logic [AW-1:0]           rem_q;
  logic [AW-1:0]           dvs_q;
  logic [16:0]             quo_q;
  logic                    neg_q;
  logic                    zero_q;
  logic [15:0]             out_q;

  logic [31:0] lat_cell [3];
  logic [15:0] frac [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign lat_cell[a] = 32'($signed(coord_q[a]) >>> FRACTION_BITS);
    if (FRACTION_BITS >= 16) begin : g_trunc
      assign frac[a] = coord_q[a][FRACTION_BITS-1 -: 16];
    end else begin : g_pad
      assign frac[a] = {coord_q[a][FRACTION_BITS-1:0], {(16-FRACTION_BITS){1'b0}}};
    end
  end

  // Axis hash operand
  logic [1:0]  axis;
  logic [31:0] axis_cell;
  logic [31:0] axis_k;
  logic [2:0]  cidx;
  logic [31:0] corner_h;

  assign axis = cmd_i.idx[2:1];
  assign cidx = cmd_i.idx;

  always_comb begin
    unique case (axis)
      2'd0:    begin axis_cell = lat_cell[0]; axis_k = fvn_pkg::AXIS_KX; end
      2'd1:    begin axis_cell = lat_cell[1]; axis_k = fvn_pkg::AXIS_KY; end
      default: begin axis_cell = lat_cell[2]; axis_k = fvn_pkg::AXIS_KZ; end
    endcase
    axis_cell = axis_cell + {31'd0, cmd_i.idx[0]};
  end

  assign corner_h = seed_q ^ hax_q[0][cidx[0]] ^ hax_q[1][cidx[1]] ^ hax_q[2][cidx[2]];

  // Hash multiplier
  logic [31:0] ma, mb, hprod;
  logic        hp_en;
  logic [31:0] hp_fold;

  assign hp_fold = xs16(hp_q);

  always_comb begin
    ma    = xs15(hp_q);
    mb    = fvn_pkg::MIX_C2;
    hp_en = 1'b0;
    unique case (cmd_i.op)
      fvn_pkg::OP_AXIS: begin
        hp_en = (cmd_i.sub != 2'd3);
        unique case (cmd_i.sub)
          2'd0:    begin ma = axis_cell;  mb = axis_k; end
          2'd1:    begin ma = xs16(hp_q); mb = fvn_pkg::MIX_C1; end
          default: begin ma = xs15(hp_q); mb = fvn_pkg::MIX_C2; end
        endcase
      end
      fvn_pkg::OP_CORNER: begin
        hp_en = (cmd_i.sub != 2'd2);
        if (cmd_i.sub == 2'd0) begin
          ma = xs16(corner_h);
          mb = fvn_pkg::MIX_C1;
        end
      end
      default: ;
    endcase
  end

  assign hprod = ma * mb;

  // Ease and blend multiplier
  logic [15:0]        tsel;
  logic [23:0]        ba, bb;
  logic [16:0]        bs;
  logic signed [25:0] m2a;
  logic signed [18:0] m2b;
  logic signed [44:0] prod_d;
  logic signed [28:0] bsum;
  logic [23:0]        bres;

  assign tsel = frac[cmd_i.idx[1:0]];
  assign ba   = pl_q[cmd_i.idx[1:0]];
  assign bb   = ph_q[cmd_i.idx[1:0]];
  assign bs   = ease_q[cmd_i.lvl];

  always_comb begin
    m2a = 26'sd0;
    m2b = 19'sd0;
    unique case (cmd_i.op)
      fvn_pkg::OP_EASE: begin
        if (cmd_i.sub == 2'd0) begin
          m2a = $signed({10'd0, tsel});
          m2b = $signed({3'd0, tsel});
        end else begin
          m2a = $signed({10'd0, prod_q[31:16]});
          m2b = $signed(19'd196608 - {2'd0, tsel, 1'b0});
        end
      end
      fvn_pkg::OP_BLEND: begin
        m2a = $signed({2'd0, bb}) - $signed({2'd0, ba});
        m2b = $signed({2'd0, bs});
      end
      default: ;
    endcase
  end

  assign prod_d = m2a * m2b;
  assign bsum   = $signed({5'd0, ba}) + $signed(prod_q[44:16]);
  assign bres   = bsum[23:0];

  // Octave term and normalization
  logic signed [25:0]      dterm;
  logic [MAX_OCTAVES:0]    den_nx;
  logic [16:0]             qneg;
  logic [15:0]             qsat;

  assign dterm  = $signed({1'b0, pl_q[0], 1'b0}) - 26'sh1000000;
  assign den_nx = {den_q, 1'b1};
  assign qneg   = 17'd0 - quo_q;

  always_comb begin
    if (zero_q) begin
      qsat = 16'd0;
    end else if (neg_q) begin
      qsat = (quo_q > 17'd32768) ? 16'h8000 : qneg[15:0];
    end else begin
      qsat = (quo_q > 17'd32767) ? 16'h7fff : quo_q[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hp_en) begin
      hp_q <= hprod;
    end
    if (cmd_i.op == fvn_pkg::OP_EASE || (cmd_i.op == fvn_pkg::OP_BLEND && cmd_i.sub == 2'd0)) begin
      prod_q <= prod_d;
    end
    unique case (cmd_i.op)
      fvn_pkg::OP_LOAD: begin
        coord_q[0] <= x_coord_i;
        coord_q[1] <= three_dim_i ? y_coord_i : 32'd0;
        coord_q[2] <= z_coord_i;
        d3_q       <= three_dim_i;
        seed_q     <= noise_seed_i;
        acc_q      <= '0;
        den_q      <= '0;
      end
      fvn_pkg::OP_EASE: begin
        if (cmd_i.sub == 2'd2) begin
          ease_q[cmd_i.idx[1:0]] <= prod_q[32:16];
        end
      end
      fvn_pkg::OP_AXIS: begin
        if (cmd_i.sub == 2'd3) begin
          hax_q[axis][cmd_i.idx[0]] <= hp_fold;
        end
      end
      fvn_pkg::OP_CORNER: begin
        if (cmd_i.sub == 2'd2) begin
          if (cidx[0]) begin
            ph_q[cidx[2:1]] <= hp_fold[23:0] & fvn_pkg::VAL_MASK[23:0];
          end else begin
            pl_q[cidx[2:1]] <= hp_fold[23:0] & fvn_pkg::VAL_MASK[23:0];
          end
        end
      end
      fvn_pkg::OP_BLEND: begin
        // Write the result back into the pair that the next level reads
        if (cmd_i.sub == 2'd1) begin
          if (cmd_i.idx[0]) begin
            ph_q[{1'b0, cmd_i.idx[1]}] <= bres;
          end else begin
            pl_q[{1'b0, cmd_i.idx[1]}] <= bres;
          end
        end
      end
      fvn_pkg::OP_ACCUM: begin
        acc_q      <= (acc_q <<< 1) + {{(AW-26){dterm[25]}}, dterm};
        den_q      <= den_nx[MAX_OCTAVES-1:0];
        coord_q[0] <= coord_q[0] << 1;
        coord_q[1] <= coord_q[1] << 1;
        coord_q[2] <= coord_q[2] << 1;
        seed_q     <= seed_q + (d3_q ? fvn_pkg::SEED_STEP_3D : fvn_pkg::SEED_STEP_2D);
      end
      fvn_pkg::OP_DIV_INIT: begin
        neg_q  <= acc_q[AW-1];
        rem_q  <= acc_q[AW-1] ? AW'(-acc_q) : AW'(acc_q);
        dvs_q  <= AW'(den_q) << 25;
        quo_q  <= '0;
        zero_q <= (den_q == '0);
      end
      fvn_pkg::OP_DIV_STEP: begin
        if (rem_q >= dvs_q) begin
          rem_q <= rem_q - dvs_q;
          quo_q <= {quo_q[15:0], 1'b1};
        end else begin
          quo_q <= {quo_q[15:0], 1'b0};
        end
        dvs_q <= dvs_q >> 1;
      end
      fvn_pkg::OP_OUT: begin
        out_q <= qsat;
      end
      default: ;
    endcase
  end

  assign noise_value_o = out_q;

endmodule

### src/fvn_ctrl.sv
// Controller: sequences the octave phases, the divider and the handshakes.
module fvn_ctrl #(
  parameter int MAX_OCTAVES = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  logic [3:0]    octave_count_i,
  output fvn_pkg::cmd_t cmd_o
);

  localparam int OW = $clog2(MAX_OCTAVES + 1);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EASE   = 8'b0000_0010,
    S_AXIS   = 8'b0000_0100,
    S_CORNER = 8'b0000_1000,
    S_BLEND  = 8'b0001_0000,
    S_ACCUM  = 8'b0010_0000,
    S_DIVIDE = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e        state_q, state_d;
  logic [4:0]    idx_q, idx_d;
  logic [1:0]    sub_q, sub_d;
  logic [1:0]    lvl_q, lvl_d;
  logic [OW-1:0] oct_q, oct_d;
  logic [OW-1:0] n_q, n_d;
  logic          out_valid_q, out_valid_d;
  logic [OW-1:0] n_clamp;
  logic [4:0]    last_j;
  logic          accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);
  assign n_clamp    = (int'(octave_count_i) > MAX_OCTAVES) ? OW'(MAX_OCTAVES)
                                                          : OW'(octave_count_i);

  always_comb begin
    unique case (lvl_q)
      2'd0:    last_j = 5'd3;
      2'd1:    last_j = 5'd1;
      default: last_j = 5'd0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    sub_d       = sub_q;
    lvl_d       = lvl_q;
    oct_d       = oct_q;
    n_d         = n_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = fvn_pkg::OP_NONE;
    cmd_o.idx   = idx_q[2:0];
    cmd_o.sub   = sub_q;
    cmd_o.lvl   = lvl_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.op = fvn_pkg::OP_LOAD;
          n_d      = n_clamp;
          oct_d    = '0;
          idx_d    = '0;
          sub_d    = '0;
          lvl_d    = '0;
          state_d  = (n_clamp == '0) ? S_DIVIDE : S_EASE;
        end
      end
      S_EASE: begin
        cmd_o.op = fvn_pkg::OP_EASE;
        if (sub_q == 2'd2) begin
          sub_d = '0;
          if (idx_q == 5'd2) begin
            idx_d   = '0;
            state_d = S_AXIS;
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      S_AXIS: begin
        cmd_o.op = fvn_pkg::OP_AXIS;
        sub_d    = sub_q + 2'd1;
        if (sub_q == 2'd3) begin
          if (idx_q == 5'd5) begin
            idx_d   = '0;
            state_d = S_CORNER;
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end
      end
      S_CORNER: begin
        cmd_o.op = fvn_pkg::OP_CORNER;
        if (sub_q == 2'd2) begin
          sub_d = '0;
          if (idx_q == 5'd7) begin
            idx_d   = '0;
            lvl_d   = '0;
            state_d = S_BLEND;
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      S_BLEND: begin
        cmd_o.op = fvn_pkg::OP_BLEND;
        if (sub_q == 2'd1) begin
          sub_d = '0;
          if (idx_q == last_j) begin
            idx_d = '0;
            if (lvl_q == 2'd2) begin
              state_d = S_ACCUM;
            end else begin
              lvl_d = lvl_q + 2'd1;
            end
          end else begin
            idx_d = idx_q + 5'd1;
          end
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      S_ACCUM: begin
        cmd_o.op = fvn_pkg::OP_ACCUM;
        oct_d    = oct_q + OW'(1);
        idx_d    = '0;
        sub_d    = '0;
        lvl_d    = '0;
        state_d  = (oct_q + OW'(1) == n_q) ? S_DIVIDE : S_EASE;
      end
      S_DIVIDE: begin
        cmd_o.op = (idx_q == 5'd0) ? fvn_pkg::OP_DIV_INIT : fvn_pkg::OP_DIV_STEP;
        if (idx_q == 5'(fvn_pkg::DIV_STEPS)) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 5'd1;
        end
      end
      S_DONE: begin
        // Hold the finished value until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = fvn_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      sub_q       <= '0;
      lvl_q       <= '0;
      oct_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      sub_q       <= sub_d;
      lvl_q       <= lvl_d;
      oct_q       <= oct_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted transfer did not start work");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside of done state");

  a_octave_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ACCUM |-> oct_q < n_q)
    else $error("octave counter ran past the octave count");

  a_blend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_BLEND |-> (sub_q <= 2'd1 && lvl_q <= 2'd2 && idx_q <= last_j))
    else $error("blend sequencer out of range");

endmodule

### src/fractal_value_noise.sv
// Top level of the fractal value noise block: configuration registers and wiring.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one sample point x, y, z in
//   signed fixed point; output channel (out_valid_o/out_ready_i) returns one
//   signed Q1.15 noise value per point. A transfer happens when valid and
//   ready are both high at a rising edge.
//   Configuration goes through the APB port: seed at 0x0, octave count at
//   0x4, 2-D/3-D mode at 0x8. Write it only while the block is idle.
// Sequence:
//   The octave count is clamped to MAX_OCTAVES. Each octave, in 2-D and
//   3-D alike, runs the ease phase, six axis hashes and eight corner hashes
//   on one shared 32x32 hash multiplier, the blend phase and one accumulate;
//   the normalization divider then runs one setup step and one step per
//   quotient bit, and a last step loads the output register. The next point
//   is taken only once the previous one leaves the datapath.
// Reset and stall:
//   Reset drops any point in flight, clears the output valid and sets the
//   registers to seed 0, four octaves, 3-D mode. A finished value waits in
//   the output register; a point accepted meanwhile is computed and holds
//   in the done state until that register is free.
module fractal_value_noise #(
  parameter int MAX_OCTAVES   = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [3:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready,
  // Sample input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic signed [31:0] z_coord_i,
  // Noise output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] noise_value_o
);

  logic [31:0]   noise_seed_q;
  logic [3:0]    octave_count_q;
  logic          three_dim_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;
  fvn_pkg::cmd_t cmd;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[3:2];

  // Register file; writes beyond the last register drop silently
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_seed_q   <= '0;
      octave_count_q <= fvn_pkg::OCTAVE_RESET;
      three_dim_q    <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        fvn_pkg::REG_SEED:   noise_seed_q   <= pwdata;
        fvn_pkg::REG_OCTAVE: octave_count_q <= pwdata[3:0];
        fvn_pkg::REG_MODE:   three_dim_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      fvn_pkg::REG_SEED:   prdata = noise_seed_q;
      fvn_pkg::REG_OCTAVE: prdata = {28'd0, octave_count_q};
      fvn_pkg::REG_MODE:   prdata = {31'd0, three_dim_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Sequencer: owns both handshakes and steps the datapath
  fvn_ctrl #(
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .octave_count_i (octave_count_q),
    .cmd_o          (cmd)
  );

  // Arithmetic: hashing, smoothstep, lerp tree, octave sum and divider
  fvn_datapath #(
    .MAX_OCTAVES   (MAX_OCTAVES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .noise_seed_i  (noise_seed_q),
    .three_dim_i   (three_dim_q),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .noise_value_o (noise_value_o)
  );

endmodule

### sim/tb_fractal_value_noise.sv
// Testbench of the fractal value noise block: directed table, random points, predictor check.
module tb_fractal_value_noise;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_OCT   = 8;
  localparam int FRAC_BITS = 16;
  localparam int N_RANDOM  = 830;
  // Drain wait: covers the worst latency at the octave limit, plus margin
  localparam int DRAIN_CYCLES = 800;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic        [3:0]  paddr;
  logic        [31:0] pwdata;
  logic        [31:0] prdata;
  logic               pready;
  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] x_coord_i;
  logic signed [31:0] y_coord_i;
  logic signed [31:0] z_coord_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [15:0] noise_value_o;

  fractal_value_noise dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .x_coord_i     (x_coord_i),
    .y_coord_i     (y_coord_i),
    .z_coord_i     (z_coord_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .noise_value_o (noise_value_o)
  );

  // Shadow copy of the configuration registers
  logic [31:0] seed_q;
  logic [3:0]  octaves_q;
  logic        mode3d_q;

  // Expected noise values, oldest first
  logic [15:0] noise_expected_q[$];
  int          mismatch_cnt;
  int          transfer_cnt;
  int          result_cnt;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          hold_off_cycles;

  // Directed rows: coordinates, optional known result
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        known;
    logic [15:0] value;
  } sample_row_t;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic logic [31:0] mix_word(logic [31:0] v);
    logic [31:0] r;
    r = v ^ (v >> 16);
    r = r * fvn_pkg::MIX_C1;
    r = r ^ (r >> 15);
    r = r * fvn_pkg::MIX_C2;
    r = r ^ (r >> 16);
    return r;
  endfunction

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy,
                                               logic [31:0] cz, logic [31:0] seed);
    logic [31:0] h;
    h = seed;
    h ^= mix_word(cx * fvn_pkg::AXIS_KX);
    h ^= mix_word(cy * fvn_pkg::AXIS_KY);
    h ^= mix_word(cz * fvn_pkg::AXIS_KZ);
    h = mix_word(h) & fvn_pkg::VAL_MASK;
    return h;
  endfunction

  function automatic logic [31:0] smooth_weight(logic [31:0] t);
    logic [63:0] t2;
    logic [63:0] s;
    t2 = (64'(t) * 64'(t)) >> 16;
    s  = (t2 * 64'(32'(3 * 65536) - 32'(2) * t)) >> 16;
    return s[31:0];
  endfunction

  function automatic logic [31:0] mix_lerp(logic [31:0] a, logic [31:0] b, logic [31:0] s);
    logic [63:0] acc;
    acc = 64'(a) * 64'(32'd65536 - s) + 64'(b) * 64'(s);
    return acc[47:16];
  endfunction

  // Hold the lattice cell and the eased fraction of one coordinate
  function automatic void cell_split(logic [31:0] u, output logic [31:0] lat,
                                     output logic [31:0] wt);
    logic [31:0] f;
    lat = $signed(u) >>> FRAC_BITS;
    f   = u & ((32'd1 << FRAC_BITS) - 32'd1);
    wt  = smooth_weight(f);
  endfunction

  function automatic logic [31:0] octave_sample(logic [31:0] x, logic [31:0] y,
                                                logic [31:0] z, logic [31:0] seed,
                                                logic d3);
    logic [31:0] cx, cy, cz, sx, sy, sz;
    logic [31:0] x00, x10, x01, x11, y0, y1;
    cell_split(x, cx, sx);
    cell_split(z, cz, sz);
    if (d3) begin
      cell_split(y, cy, sy);
    end else begin
      cy = '0;
      sy = '0;
    end
    x00 = mix_lerp(lattice_hash(cx, cy, cz, seed),
                   lattice_hash(cx + 32'd1, cy, cz, seed), sx);
    x10 = mix_lerp(lattice_hash(cx, cy + 32'd1, cz, seed),
                   lattice_hash(cx + 32'd1, cy + 32'd1, cz, seed), sx);
    x01 = mix_lerp(lattice_hash(cx, cy, cz + 32'd1, seed),
                   lattice_hash(cx + 32'd1, cy, cz + 32'd1, seed), sx);
    x11 = mix_lerp(lattice_hash(cx, cy + 32'd1, cz + 32'd1, seed),
                   lattice_hash(cx + 32'd1, cy + 32'd1, cz + 32'd1, seed), sx);
    if (!d3) return mix_lerp(x00, x01, sz);
    y0 = mix_lerp(x00, x10, sy);
    y1 = mix_lerp(x01, x11, sy);
    return mix_lerp(y0, y1, sz);
  endfunction

  function automatic logic [15:0] fbm_noise(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int unsigned n;
    logic [31:0] stride;
    logic [31:0] v;
    longint      sum;
    longint      norm;
    longint      q;
    longint      w;
    n      = 32'(octaves_q);
    stride = mode3d_q ? fvn_pkg::SEED_STEP_3D : fvn_pkg::SEED_STEP_2D;
    sum    = 0;
    norm   = 0;
    if (n > MAX_OCT) n = MAX_OCT;
    for (int i = 0; i < n; i++) begin
      v    = octave_sample(x << i, y << i, z << i, seed_q + 32'(i) * stride, mode3d_q);
      w    = longint'(1) << (MAX_OCT - 1 - i);
      sum += (2 * longint'(v) - longint'(64'h0100_0000)) * w;
      norm += w;
    end
    if (norm == 0) return 16'd0;
    q = sum / (norm * 512);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  // ---------------------------------------------------------------------
  // Clock, reset, time limit
  // ---------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stall, or a long counted hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_ready_i     <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check each output transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_cnt++;
      if (noise_expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %0d", noise_value_o);
      end else begin
        logic [15:0] want;
        want = noise_expected_q.pop_front();
        if (noise_value_o !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("noise_value mismatch: expected %0d got %0d",
                     $signed(want), noise_value_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sender helpers
  // ---------------------------------------------------------------------
  // Offer one point, hold it until transfer, then queue its expected value;
  // valid stays high after the transfer unless idling or draining follows
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic known, logic [15:0] value);
    logic [15:0] pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pred = fbm_noise(x, y, z);
    if (known && pred !== value)
      $display("table row disagrees with predictor: %0d vs %0d", $signed(value),
               $signed(pred));
    in_valid_i <= 1'b1;
    x_coord_i  <= x;
    y_coord_i  <= y;
    z_coord_i  <= z;
    do @(posedge clk_i); while (!in_ready_o);
    noise_expected_q.push_back(known ? value : pred);
    transfer_cnt++;
  endtask

  // Pause until every expected value has come, then let the datapath settle
  task automatic drain_block();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (noise_expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (noise_expected_q.size() != 0) begin
      $display("TB_ERROR");
      $finish;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register through the APB port: setup, access, then back to idle
  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      fvn_pkg::REG_SEED:   seed_q    = value;
      fvn_pkg::REG_OCTAVE: octaves_q = value[3:0];
      fvn_pkg::REG_MODE:   mode3d_q  = value[0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0:       return 32'h8000_0000 | $urandom_range(255);
      1:       return 32'h7fff_ffff - $urandom_range(255);
      2:       return $urandom_range(32'h0003_ffff) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    sample_row_t rows[$];
    logic [31:0] seeds[4];
    int          phase_left;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    x_coord_i       = '0;
    y_coord_i       = '0;
    z_coord_i       = '0;
    mismatch_cnt    = 0;
    transfer_cnt    = 0;
    result_cnt      = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    seed_q          = 32'd0;
    octaves_q       = fvn_pkg::OCTAVE_RESET;
    mode3d_q        = 1'b1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings: origin, extremes, all-ones bits, mixed patterns
    rows = '{
      '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 16'd0},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 16'd0},
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 16'd0},
      '{32'h0000_ffff, 32'hffff_0000, 32'h0001_8000, 1'b0, 16'd0},
      '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 1'b0, 16'd0}
    };
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known,
                                 rows[i].value);
    drain_block();

    // Zero octaves: the result is always 0
    reg_write(fvn_pkg::REG_OCTAVE, 32'd0);
    rows = '{
      '{32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 1'b1, 16'd0},
      '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1, 16'd0}
    };
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known,
                                 rows[i].value);
    drain_block();

    // Octave count above the limit clamps; all-ones seed; 2-D mode ignores y
    reg_write(fvn_pkg::REG_OCTAVE, 32'd15);
    reg_write(fvn_pkg::REG_SEED, 32'hffff_ffff);
    reg_write(fvn_pkg::REG_MODE, 32'd0);
    rows = '{
      '{32'h0003_4000, 32'h0000_0000, 32'hfffd_c000, 1'b0, 16'd0},
      '{32'h0003_4000, 32'hffff_ffff, 32'hfffd_c000, 1'b0, 16'd0},
      '{32'h7fff_ffff, 32'h1234_5678, 32'h8000_0000, 1'b0, 16'd0},
      '{32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 1'b0, 16'd0}
    };
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known,
                                 rows[i].value);
    drain_block();

    // Single octave, 3-D, a write to an unused index that must change nothing
    reg_write(fvn_pkg::REG_OCTAVE, 32'd1);
    reg_write(fvn_pkg::REG_MODE, 32'd1);
    reg_write(2'd3, 32'hdead_beef);
    rows = '{
      '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1'b0, 16'd0},
      '{32'hffff_8000, 32'h0001_0000, 32'h7fff_0000, 1'b0, 16'd0}
    };
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known,
                                 rows[i].value);
    drain_block();

    // Random part: phases cycle through settings and idling patterns
    seeds = '{32'd0, 32'hffff_ffff, 32'h8000_0001, 32'h0};
    for (int ph = 0; ph < 8; ph++) begin
      seeds[3] = $urandom;
      reg_write(fvn_pkg::REG_SEED, seeds[ph % 4]);
      // Mostly small octave counts keep the run short; extremes still show up
      reg_write(fvn_pkg::REG_OCTAVE,
                (ph == 3) ? 32'd8 : (ph == 6) ? 32'd9 : $urandom_range(1, 3));
      reg_write(fvn_pkg::REG_MODE, {31'd0, ph[0]});
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
      // Hold the receiver off long enough that the block backs up its input
      if (ph == 2) hold_off_cycles = 2000;
      phase_left = N_RANDOM / 8;
      while (phase_left > 0) begin
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 16'd0);
        phase_left--;
        if ($urandom_range(99) < 2) drain_block();
      end
      drain_block();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_block();
    $display("covered %0d points and %0d results over 2-D/3-D, octave counts 0..15,",
             transfer_cnt, result_cnt);
    $display("extreme seeds and coordinates, with idle, stall and hold-off phases");
    if (mismatch_cnt == 0 && noise_expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
